// ===== sv/emss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package emss_pkg;

    localparam logic [1:0] OP_STEP   = 2'd0;
    localparam logic [1:0] OP_INJECT = 2'd1;
    localparam logic [1:0] OP_FILL   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] CFG_ROWS  = 3'd0;
    localparam logic [2:0] CFG_COLS  = 3'd1;
    localparam logic [2:0] CFG_A     = 3'd2;
    localparam logic [2:0] CFG_B     = 3'd3;
    localparam logic [2:0] CFG_EPS   = 3'd4;
    localparam logic [2:0] CFG_DIFF  = 3'd5;
    localparam logic [2:0] CFG_DT    = 3'd6;
    localparam logic [2:0] CFG_KICK  = 3'd7;

    localparam int FRAC_BITS = 12;
    localparam int FRAC_HALF = 2048;
    localparam int C3_SHIFT  = 24;
    localparam int C3_HALF   = 25165824;   // 3 * 2^23
    localparam int REST_U    = -4915;
    localparam int REST_V    = -2560;

    typedef struct packed {
        logic [1:0] op;
        logic [6:0] row;
        logic [7:0] col;
        logic [4:0] radius;
    } in_req_t;

    typedef struct packed {
        logic signed [15:0] u_value;
        logic signed [15:0] v_value;
    } out_res_t;

endpackage

`default_nettype wire

// ===== sv/emss_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module emss_ram #(
    parameter int W  = 16,
    parameter int AB = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AB-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AB-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [0:(1 << AB)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/excitable_medium_stencil_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// FitzHugh-Nagumo grid engine, one request at a time, in_stall high while busy.
// A step sweeps all MAX_ROWS*MAX_COLS cells: a cell outside the active grid
// is read and copied to the other bank; an active cell's time is set by the
// five u reads for the stencil through the single read port and the one
// shared multiplier used eight times, the divide by three of u^3 being a
// reciprocal multiply on that same unit. An inject sweeps the (2*radius+1)^2
// square, a fill the rows*cols active cells, a read a wait and an output
// state; a read stays busy longer while the previous result is
// stalled. Memories start undefined: fill before stepping or reading.
// No clearing pass after reset.
module excitable_medium_stencil_step #(
    parameter int MAX_ROWS   = 128,
    parameter int MAX_COLS   = 256,
    parameter int VALUE_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire emss_pkg::in_req_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output emss_pkg::out_res_t     out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    import emss_pkg::*;

    localparam int VB  = VALUE_BITS;
    localparam int RB  = $clog2(MAX_ROWS);
    localparam int CB  = $clog2(MAX_COLS);
    localparam int AB  = 1 + RB + CB;
    localparam int ERB = $clog2(MAX_ROWS + 1);
    localparam int ECB = $clog2(MAX_COLS + 1);
    localparam int LW  = VB + 4;
    localparam int MW  = 3*VB - 23;
    localparam int DW  = (MW + 1 > VB + 8) ? MW + 1 : VB + 8;
    localparam int MAW = (2*VB > DW) ? 2*VB : DW;
    localparam int MBS = (VB > 15) ? VB + 1 : 17;
    localparam int MBW = (MW + 1 > MBS) ? MW + 1 : MBS;
    localparam int PW  = MAW + MBW;
    localparam int AW  = PW + 1;

    // ceil(2^(MW+1)/3): exact floor divide by three for operands below 2^MW
    localparam logic [MW-1:0] C3_RECIP = MW'(((64'd1 << (MW + 1)) + 64'd2) / 64'd3);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RD    = 5'd1;
    localparam logic [4:0] ST_UU    = 5'd2;
    localparam logic [4:0] ST_UUU   = 5'd3;
    localparam logic [4:0] ST_C3    = 5'd4;
    localparam logic [4:0] ST_DF    = 5'd5;
    localparam logic [4:0] ST_BV    = 5'd6;
    localparam logic [4:0] ST_EPS   = 5'd7;
    localparam logic [4:0] ST_DV    = 5'd8;
    localparam logic [4:0] ST_DU    = 5'd10;
    localparam logic [4:0] ST_MU    = 5'd11;
    localparam logic [4:0] ST_UN    = 5'd12;
    localparam logic [4:0] ST_VN    = 5'd13;
    localparam logic [4:0] ST_INJ   = 5'd14;
    localparam logic [4:0] ST_FILL  = 5'd15;
    localparam logic [4:0] ST_RDW   = 5'd16;
    localparam logic [4:0] ST_RDOUT = 5'd17;

    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (VB-1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    function automatic logic signed [AW-1:0] rnd12(input logic signed [AW-1:0] x);
        logic [AW-1:0] mag;
        logic [AW-1:0] q;
        mag   = x[AW-1] ? AW'(-x) : AW'(x);
        q     = (mag + AW'(FRAC_HALF)) >> FRAC_BITS;
        rnd12 = x[AW-1] ? -signed'(q) : signed'(q);
    endfunction

    function automatic logic signed [VB-1:0] sat(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] y;
        y   = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        sat = y[VB-1:0];
    endfunction

    function automatic logic signed [15:0] to16(input logic signed [VB-1:0] x);
        logic signed [VB+15:0] t;
        t    = (VB+16)'(x);
        to16 = t[15:0];
    endfunction

    // control
    logic [4:0]      state_reg;
    logic            bank_reg;
    logic            out_valid_reg;
    logic [RB-1:0]   r_reg;
    logic [CB-1:0]   c_reg;
    logic [2:0]      k_reg;
    logic signed [6:0] dr_reg, dc_reg;

    logic [7:0]  grid_rows_reg;
    logic [8:0]  grid_cols_reg;
    logic [14:0] coef_a_reg, coef_b_reg, coef_eps_reg, coef_diff_reg, time_step_reg;
    logic [15:0] kick_reg;

    // datapath
    logic [6:0]  row_reg;
    logic [7:0]  col_reg;
    logic [4:0]  rad_reg;
    logic        rd_zero_reg;
    logic signed [VB-1:0] u_reg, v_reg, un_reg;
    logic signed [LW-1:0] lap_acc_reg, lap_reg;
    logic signed [PW-1:0] p_reg;
    logic [MW-1:0] msh_reg;
    logic          sgn_reg;
    logic signed [AW-1:0] df_reg, bv_reg, dv_reg, du_reg;

    // memories
    logic          u_we, v_we, u_re, v_re;
    logic [AB-1:0] u_waddr, v_waddr, raddr;
    logic [VB-1:0] u_wdata, v_wdata, u_rdata, v_rdata;
    logic signed [VB-1:0] u_rd, v_rd;

    emss_ram #(.W(VB), .AB(AB)) u_ram (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .re(u_re), .raddr(raddr), .rdata(u_rdata)
    );

    emss_ram #(.W(VB), .AB(AB)) v_ram (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .re(v_re), .raddr(raddr), .rdata(v_rdata)
    );

    assign u_rd = signed'(u_rdata);
    assign v_rd = signed'(v_rdata);

    // effective grid size
    logic [ERB-1:0] rows_eff;
    logic [ECB-1:0] cols_eff;
    always_comb
    begin
        if (grid_rows_reg == 8'd0)
            rows_eff = ERB'(1);
        else if (int'(grid_rows_reg) > MAX_ROWS)
            rows_eff = ERB'(MAX_ROWS);
        else
            rows_eff = ERB'(grid_rows_reg);
        if (grid_cols_reg == 9'd0)
            cols_eff = ECB'(1);
        else if (int'(grid_cols_reg) > MAX_COLS)
            cols_eff = ECB'(MAX_COLS);
        else
            cols_eff = ECB'(grid_cols_reg);
    end

    logic          act, last_cell, in_take, in_range, out_load;
    logic [RB-1:0] r_up, r_dn, rsel;
    logic [CB-1:0] c_lf, c_rt, csel;

    assign act       = (ERB'(r_reg) < rows_eff) && (ECB'(c_reg) < cols_eff);
    assign last_cell = (r_reg == RB'(MAX_ROWS - 1)) && (c_reg == CB'(MAX_COLS - 1));
    assign in_take   = in_valid && !in_stall;
    assign in_range  = (int'(in_data.row) < MAX_ROWS) && (int'(in_data.col) < MAX_COLS);
    assign out_load  = (state_reg == ST_RDOUT) && (!out_valid_reg || !out_stall);

    assign r_up = (r_reg == '0) ? '0 : r_reg - RB'(1);
    assign r_dn = ((ERB'(r_reg) + ERB'(1)) < rows_eff) ? r_reg + RB'(1)
                                                       : RB'(rows_eff - ERB'(1));
    assign c_lf = (c_reg == '0) ? '0 : c_reg - CB'(1);
    assign c_rt = ((ECB'(c_reg) + ECB'(1)) < cols_eff) ? c_reg + CB'(1)
                                                       : CB'(cols_eff - ECB'(1));

    // disc cell
    logic signed [11:0] ir, ic;
    logic [11:0]        dist2, rad2;
    logic               inj_ok;
    logic signed [6:0]  rad_s;
    assign rad_s  = signed'({2'b00, rad_reg});
    assign ir     = 12'(signed'({1'b0, row_reg})) + 12'(dr_reg);
    assign ic     = 12'(signed'({1'b0, col_reg})) + 12'(dc_reg);
    assign dist2  = 12'(dr_reg * dr_reg) + 12'(dc_reg * dc_reg);
    assign rad2   = 12'(rad_reg * rad_reg);
    assign inj_ok = (dist2 <= rad2) && !ir[11] && !ic[11]
                    && (ir < 12'(signed'({1'b0, rows_eff})))
                    && (ic < 12'(signed'({1'b0, cols_eff})));

    logic signed [VB-1:0] vn;
    assign vn = sat(AW'(v_reg) + rnd12(AW'(p_reg)));

    // memory ports
    always_comb
    begin
        u_we = 1'b0; v_we = 1'b0; u_re = 1'b0; v_re = 1'b0;
        u_waddr = {~bank_reg, r_reg, c_reg};
        v_waddr = {~bank_reg, r_reg, c_reg};
        u_wdata = u_rdata;
        v_wdata = v_rdata;
        rsel = r_reg;
        csel = c_reg;
        raddr = {bank_reg, rsel, csel};
        case (state_reg)
            ST_IDLE:
            begin
                raddr = {bank_reg, RB'(in_data.row), CB'(in_data.col)};
                u_re  = in_take && (in_data.op == OP_READ) && in_range;
                v_re  = u_re;
            end
            ST_RD:
            begin
                case (k_reg)
                    3'd1:    rsel = r_up;
                    3'd2:    rsel = r_dn;
                    3'd3:    csel = c_lf;
                    3'd4:    csel = c_rt;
                    default: rsel = r_reg;
                endcase
                raddr = {bank_reg, rsel, csel};
                u_re  = act ? (k_reg <= 3'd4) : (k_reg == 3'd0);
                v_re  = (k_reg == 3'd0);
                u_we  = !act && (k_reg == 3'd1);
                v_we  = u_we;
            end
            ST_VN:
            begin
                u_we = 1'b1; v_we = 1'b1;
                u_wdata = un_reg;
                v_wdata = vn;
            end
            ST_INJ:
            begin
                u_we    = inj_ok;
                u_waddr = {bank_reg, ir[RB-1:0], ic[CB-1:0]};
                u_wdata = sat(AW'(signed'(kick_reg)));
            end
            ST_FILL:
            begin
                u_we = 1'b1; v_we = 1'b1;
                u_waddr = {bank_reg, r_reg, c_reg};
                v_waddr = {bank_reg, r_reg, c_reg};
                u_wdata = sat(AW'(REST_U));
                v_wdata = sat(AW'(REST_V));
            end
            default:
            begin
                u_we = 1'b0;
            end
        endcase
    end

    // shared multiplier operands
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [AW-1:0]  eps_opnd;
    assign eps_opnd = AW'(u_reg) + AW'(signed'({1'b0, coef_a_reg})) - bv_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_UU:
            begin
                mul_a = MAW'(u_reg);
                mul_b = MBW'(u_reg);
            end
            ST_UUU:
            begin
                mul_a = MAW'(signed'(p_reg[2*VB-1:0]));
                mul_b = MBW'(u_reg);
            end
            ST_C3:
            begin
                mul_a = MAW'(lap_reg);
                mul_b = MBW'(signed'({1'b0, coef_diff_reg}));
            end
            ST_DF:
            begin
                mul_a = MAW'(v_reg);
                mul_b = MBW'(signed'({1'b0, coef_b_reg}));
            end
            ST_EPS:
            begin
                mul_a = signed'(eps_opnd[MAW-1:0]);
                mul_b = MBW'(signed'({1'b0, coef_eps_reg}));
            end
            ST_DV:
            begin
                // |u^3| / 3 by reciprocal
                mul_a = MAW'(signed'({1'b0, msh_reg}));
                mul_b = MBW'(signed'({1'b0, C3_RECIP}));
            end
            ST_MU:
            begin
                mul_a = signed'(du_reg[MAW-1:0]);
                mul_b = MBW'(signed'({1'b0, time_step_reg}));
            end
            ST_UN:
            begin
                mul_a = signed'(dv_reg[MAW-1:0]);
                mul_b = MBW'(signed'({1'b0, time_step_reg}));
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    // control path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            grid_rows_reg <= 8'd128;
            grid_cols_reg <= 9'd256;
            coef_a_reg    <= 15'd2867;
            coef_b_reg    <= 15'd3277;
            coef_eps_reg  <= 15'd328;
            coef_diff_reg <= 15'd410;
            time_step_reg <= 15'd164;
            kick_reg      <= 16'd8192;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROWS: grid_rows_reg <= cfg_data[7:0];
                    CFG_COLS: grid_cols_reg <= cfg_data[8:0];
                    CFG_A:    coef_a_reg    <= cfg_data[14:0];
                    CFG_B:    coef_b_reg    <= cfg_data[14:0];
                    CFG_EPS:  coef_eps_reg  <= cfg_data[14:0];
                    CFG_DIFF: coef_diff_reg <= cfg_data[14:0];
                    CFG_DT:   time_step_reg <= cfg_data[14:0];
                    CFG_KICK: kick_reg      <= cfg_data;
                    default:  kick_reg      <= kick_reg;
                endcase
            end

            if (out_valid_reg && !out_stall && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        r_reg  <= '0;
                        c_reg  <= '0;
                        k_reg  <= '0;
                        dr_reg <= -signed'({2'b00, in_data.radius});
                        dc_reg <= -signed'({2'b00, in_data.radius});
                        case (in_data.op)
                            OP_STEP:   state_reg <= ST_RD;
                            OP_INJECT: state_reg <= ST_INJ;
                            OP_FILL:   state_reg <= ST_FILL;
                            default:   state_reg <= ST_RDW;
                        endcase
                    end
                end
                ST_RD:
                begin
                    if (!act && k_reg == 3'd1)
                    begin
                        k_reg <= '0;
                        if (last_cell)
                        begin
                            bank_reg  <= ~bank_reg;
                            state_reg <= ST_IDLE;
                        end
                        else if (c_reg == CB'(MAX_COLS - 1))
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + RB'(1);
                        end
                        else
                            c_reg <= c_reg + CB'(1);
                    end
                    else if (act && k_reg == 3'd5)
                        state_reg <= ST_UU;
                    else
                        k_reg <= k_reg + 3'd1;
                end
                ST_UU:  state_reg <= ST_UUU;
                ST_UUU: state_reg <= ST_C3;
                ST_C3:  state_reg <= ST_DF;
                ST_DF:  state_reg <= ST_BV;
                ST_BV:  state_reg <= ST_EPS;
                ST_EPS: state_reg <= ST_DV;
                ST_DV:  state_reg <= ST_DU;
                ST_DU:  state_reg <= ST_MU;
                ST_MU:  state_reg <= ST_UN;
                ST_UN:  state_reg <= ST_VN;
                ST_VN:
                begin
                    k_reg <= '0;
                    if (last_cell)
                    begin
                        bank_reg  <= ~bank_reg;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_RD;
                        if (c_reg == CB'(MAX_COLS - 1))
                        begin
                            c_reg <= '0;
                            r_reg <= r_reg + RB'(1);
                        end
                        else
                            c_reg <= c_reg + CB'(1);
                    end
                end
                ST_INJ:
                begin
                    if (dc_reg == rad_s)
                    begin
                        if (dr_reg == rad_s)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            dr_reg <= dr_reg + 7'sd1;
                            dc_reg <= -rad_s;
                        end
                    end
                    else
                        dc_reg <= dc_reg + 7'sd1;
                end
                ST_FILL:
                begin
                    if (ECB'(c_reg) == cols_eff - ECB'(1))
                    begin
                        c_reg <= '0;
                        if (ERB'(r_reg) == rows_eff - ERB'(1))
                            state_reg <= ST_IDLE;
                        else
                            r_reg <= r_reg + RB'(1);
                    end
                    else
                        c_reg <= c_reg + CB'(1);
                end
                ST_RDW: state_reg <= ST_RDOUT;
                ST_RDOUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    logic [AW-1:0] c3_mag;
    logic [AW-1:0] c3_sh;
    logic [MW-1:0] c3_q;
    logic signed [AW-1:0] c3_v;
    assign c3_mag = p_reg[PW-1] ? AW'(-AW'(p_reg)) : AW'(AW'(p_reg));
    assign c3_sh  = (c3_mag + AW'(C3_HALF)) >> C3_SHIFT;
    assign c3_q   = p_reg[MW+1 +: MW];
    assign c3_v   = sgn_reg ? -signed'(AW'(c3_q)) : signed'(AW'(c3_q));

    always_ff @(posedge clk)
    begin
        p_reg <= PW'(mul_a) * PW'(mul_b);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    row_reg     <= in_data.row;
                    col_reg     <= in_data.col;
                    rad_reg     <= in_data.radius;
                    rd_zero_reg <= !in_range;
                end
            end
            ST_RD:
            begin
                if (act)
                begin
                    case (k_reg)
                        3'd1:
                        begin
                            u_reg <= u_rd;
                            v_reg <= v_rd;
                        end
                        3'd2:    lap_acc_reg <= LW'(u_rd);
                        3'd3,
                        3'd4,
                        3'd5:    lap_acc_reg <= lap_acc_reg + LW'(u_rd);
                        default: lap_acc_reg <= lap_acc_reg;
                    endcase
                end
            end
            ST_UU:  lap_reg <= lap_acc_reg - (LW'(u_reg) <<< 2);
            ST_C3:
            begin
                sgn_reg <= p_reg[PW-1];
                msh_reg <= c3_sh[MW-1:0];
            end
            ST_DF:  df_reg <= rnd12(AW'(p_reg));
            ST_BV:  bv_reg <= rnd12(AW'(p_reg));
            ST_DV:  dv_reg <= rnd12(AW'(p_reg));
            ST_DU:  du_reg <= AW'(u_reg) - c3_v - AW'(v_reg) + df_reg;
            ST_UN:  un_reg <= sat(AW'(u_reg) + rnd12(AW'(p_reg)));
            ST_RDOUT:
            begin
                if (out_load)
                begin
                    out_data.u_value <= rd_zero_reg ? 16'sd0 : to16(u_rd);
                    out_data.v_value <= rd_zero_reg ? 16'sd0 : to16(v_rd);
                end
            end
            default: un_reg <= un_reg;
        endcase
    end

`ifndef SYNTH
    a_new_bank_only: assert property (@(posedge clk) disable iff (!rst_n)
        (u_we && (state_reg == ST_VN || state_reg == ST_RD))
            |-> (u_waddr[AB-1] != bank_reg))
        else $error("step wrote into the current bank");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RDOUT))
        else $error("result raised outside a read");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("request taken but block not busy");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_excitable_medium_stencil_step.sv =====
`timescale 1ns / 1ps

module tb_excitable_medium_stencil_step;
    import emss_pkg::*;

    localparam int NROWS = 128;
    localparam int NCOLS = 256;
    localparam int PLANE = NROWS * NCOLS;
    localparam longint ONE = 4096;
    localparam longint CYCLE_LIMIT = 40000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_res_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    excitable_medium_stencil_step DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the grid and registers
    int act_mem [2][PLANE];
    int inh_mem [2][PLANE];
    bit bank;
    logic [7:0] m_rows;
    logic [8:0] m_cols;
    logic [14:0] m_a, m_b, m_eps, m_diff, m_dt;
    logic signed [15:0] m_kick;

    in_req_t pending_reqs[$];
    out_res_t expected_reads[$];
    int errors = 0;
    int idle_pct = 10;
    bit hold = 1'b0;
    bit in_fire = 1'b0;
    longint cycles = 0;

    function automatic longint rnd_div(longint x, longint d);
        if (x >= 0)
            return (x + d / 2) / d;
        return -((-x + d / 2) / d);
    endfunction

    function automatic longint sat16(longint x);
        if (x > 32767)
            return 32767;
        if (x < -32768)
            return -32768;
        return x;
    endfunction

    function automatic int active_rows();
        if (m_rows == 0)
            return 1;
        return (m_rows > NROWS) ? NROWS : int'(m_rows);
    endfunction

    function automatic int active_cols();
        if (m_cols == 0)
            return 1;
        return (m_cols > NCOLS) ? NCOLS : int'(m_cols);
    endfunction

    function automatic void euler_step();
        int rows;
        int cols;
        bit nb;
        int idx;
        int ru, rd, cl, cr;
        longint u, v, lap, c3, du, dv, bv;
        rows = active_rows();
        cols = active_cols();
        nb = ~bank;
        for (int r = 0; r < NROWS; r++)
        begin
            for (int c = 0; c < NCOLS; c++)
            begin
                idx = r * NCOLS + c;
                if (r >= rows || c >= cols)
                begin
                    act_mem[nb][idx] = act_mem[bank][idx];
                    inh_mem[nb][idx] = inh_mem[bank][idx];
                    continue;
                end
                u = longint'(act_mem[bank][idx]);
                v = longint'(inh_mem[bank][idx]);
                ru = (r > 0) ? r - 1 : 0;
                rd = (r < rows - 1) ? r + 1 : rows - 1;
                cl = (c > 0) ? c - 1 : 0;
                cr = (c < cols - 1) ? c + 1 : cols - 1;
                lap = longint'(act_mem[bank][ru * NCOLS + c]) + act_mem[bank][rd * NCOLS + c]
                    + act_mem[bank][r * NCOLS + cl] + act_mem[bank][r * NCOLS + cr] - 4 * u;
                c3 = rnd_div(u * u * u, 3 * ONE * ONE);
                du = u - c3 - v + rnd_div(longint'(m_diff) * lap, ONE);
                bv = rnd_div(longint'(m_b) * v, ONE);
                dv = rnd_div(longint'(m_eps) * (u + longint'(m_a) - bv), ONE);
                act_mem[nb][idx] = int'(sat16(u + rnd_div(longint'(m_dt) * du, ONE)));
                inh_mem[nb][idx] = int'(sat16(v + rnd_div(longint'(m_dt) * dv, ONE)));
            end
        end
        bank = nb;
    endfunction

    function automatic void apply_request(in_req_t req);
        int rows;
        int cols;
        int rad;
        int r, c;
        out_res_t res;
        rows = active_rows();
        cols = active_cols();
        case (req.op)
            OP_STEP:
                euler_step();
            OP_INJECT:
            begin
                rad = int'(req.radius);
                for (int dr = -rad; dr <= rad; dr++)
                    for (int dc = -rad; dc <= rad; dc++)
                    begin
                        r = int'(req.row) + dr;
                        c = int'(req.col) + dc;
                        if (dr * dr + dc * dc > rad * rad)
                            continue;
                        if (r < 0 || r >= rows || c < 0 || c >= cols)
                            continue;
                        act_mem[bank][r * NCOLS + c] = int'(m_kick);
                    end
            end
            OP_FILL:
                for (int rr = 0; rr < rows; rr++)
                    for (int cc = 0; cc < cols; cc++)
                    begin
                        act_mem[bank][rr * NCOLS + cc] = REST_U;
                        inh_mem[bank][rr * NCOLS + cc] = REST_V;
                    end
            default:
            begin
                res.u_value = 16'(act_mem[bank][int'(req.row) * NCOLS + int'(req.col)]);
                res.v_value = 16'(inh_mem[bank][int'(req.row) * NCOLS + int'(req.col)]);
                expected_reads.push_back(res);
            end
        endcase
    endfunction

    // request side acceptance and result checking
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
            apply_request(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected read result u=%0d v=%0d",
                             out_data.u_value, out_data.v_value);
            end
            else
            begin
                if (out_data.u_value !== expected_reads[0].u_value ||
                    out_data.v_value !== expected_reads[0].v_value)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("read mismatch: expected u=%0d v=%0d, got u=%0d v=%0d",
                                 expected_reads[0].u_value, expected_reads[0].v_value,
                                 out_data.u_value, out_data.v_value);
                end
                void'(expected_reads.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_reqs.size() != 0 && !hold && $urandom_range(99) >= idle_pct)
                begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_reads.size() != 0 || in_valid)
            @(posedge clk);
        // last request may still be busy without producing a result
        repeat (3) @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ROWS: m_rows = val[7:0];
            CFG_COLS: m_cols = val[8:0];
            CFG_A:    m_a = val[14:0];
            CFG_B:    m_b = val[14:0];
            CFG_EPS:  m_eps = val[14:0];
            CFG_DIFF: m_diff = val[14:0];
            CFG_DT:   m_dt = val[14:0];
            default:  m_kick = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_coefs(logic [14:0] a, logic [14:0] b, logic [14:0] eps,
                               logic [14:0] diff, logic [14:0] dt, logic [15:0] kick);
        write_reg(CFG_A, {1'b0, a});
        write_reg(CFG_B, {1'b0, b});
        write_reg(CFG_EPS, {1'b0, eps});
        write_reg(CFG_DIFF, {1'b0, diff});
        write_reg(CFG_DT, {1'b0, dt});
        write_reg(CFG_KICK, kick);
    endtask

    task automatic add_req(logic [1:0] op, logic [6:0] r, logic [7:0] c, logic [4:0] rad);
        in_req_t req;
        req.op = op;
        req.row = r;
        req.col = c;
        req.radius = rad;
        pending_reqs.push_back(req);
    endtask

    // steps are slow, so they stay rare; every cell is written once set-up is done
    task automatic add_random(int n);
        int pick;
        logic [1:0] op;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                op = OP_STEP;
            else if (pick < 40)
                op = OP_INJECT;
            else if (pick < 50)
                op = OP_FILL;
            else
                op = OP_READ;
            add_req(op, 7'($urandom), 8'($urandom), 5'($urandom));
        end
    endtask

    initial
    begin
        bank = 1'b0;
        m_rows = 8'd128;
        m_cols = 9'd256;
        m_a = 15'd2867;
        m_b = 15'd3277;
        m_eps = 15'd328;
        m_diff = 15'd410;
        m_dt = 15'd164;
        m_kick = 16'sd8192;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // whole bank 0 at rest, then one small step writes all of bank 1
        add_req(OP_FILL, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd127, 8'd255, 5'd0);
        add_req(OP_INJECT, 7'd127, 8'd255, 5'd0);
        add_req(OP_READ, 7'd127, 8'd255, 5'd0);
        add_req(OP_READ, 7'd0, 8'd0, 5'd0);
        drain();

        write_reg(CFG_ROWS, 16'd4);
        write_reg(CFG_COLS, 16'd6);
        add_req(OP_STEP, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd3, 8'd5, 5'd0);
        add_req(OP_READ, 7'd127, 8'd255, 5'd0);
        add_req(OP_INJECT, 7'd1, 8'd2, 5'd0);
        add_req(OP_INJECT, 7'd127, 8'd255, 5'd31);
        add_req(OP_READ, 7'd3, 8'd5, 5'd0);
        add_req(OP_STEP, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd1, 8'd2, 5'd0);
        add_req(OP_READ, 7'd2, 8'd3, 5'd0);
        add_req(OP_INJECT, 7'd2, 8'd3, 5'd1);
        add_req(OP_STEP, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd2, 8'd4, 5'd0);
        add_req(OP_READ, 7'd100, 8'd200, 5'd0);
        add_req(OP_FILL, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd0, 8'd5, 5'd0);
        // part way through, hold the request side until every read has come back
        while (pending_reqs.size() > 8)
            @(posedge clk);
        hold = 1'b1;
        while (expected_reads.size() != 0 || in_valid)
            @(posedge clk);
        hold = 1'b0;
        drain();

        // saturating extremes, zero grid size acts as one
        write_reg(CFG_ROWS, 16'd0);
        write_reg(CFG_COLS, 16'd0);
        write_coefs(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 16'h8000);
        add_req(OP_INJECT, 7'd0, 8'd0, 5'd3);
        add_req(OP_STEP, 7'd0, 8'd0, 5'd0);
        add_req(OP_READ, 7'd0, 8'd0, 5'd0);
        add_random(20);
        drain();

        // oversized rows clamp to the maximum, all coefficients zero
        write_reg(CFG_ROWS, 16'd255);
        write_reg(CFG_COLS, 16'd1);
        write_coefs(15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 16'h7FFF);
        idle_pct = 0;
        add_random(20);
        drain();
        idle_pct = 10;

        write_reg(CFG_ROWS, 16'd1);
        write_reg(CFG_COLS, 16'd511);
        write_coefs(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom),
                    15'($urandom), 16'($urandom));
        add_random(20);
        drain();

        write_reg(CFG_ROWS, 16'd128);
        write_reg(CFG_COLS, 16'd1);
        write_coefs(15'd2867, 15'd3277, 15'd328, 15'd410, 15'd164, 16'd8192);
        add_random(20);
        drain();

        write_reg(CFG_ROWS, 16'($urandom_range(1, 8)));
        write_reg(CFG_COLS, 16'($urandom_range(1, 8)));
        write_coefs(15'($urandom_range(0, 8191)), 15'($urandom_range(0, 8191)),
                    15'($urandom_range(0, 2047)), 15'($urandom_range(0, 4095)),
                    15'($urandom_range(0, 2047)), 16'($urandom));
        add_random(20);
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/emss_pkg.sv
sv/emss_ram.sv
sv/excitable_medium_stencil_step.sv
verif/tb_excitable_medium_stencil_step.sv
